>>> rtl/iuhg_pkg.sv
// Shared types and constants of the IPv4/UDP header generator.
`timescale 1ns / 1ps

package iuhg_pkg;

  // Header geometry
  localparam int unsigned NumWords       = 14;
  localparam int unsigned PosWidth       = 4;
  localparam int unsigned LenWidth       = 11;
  localparam int unsigned IpSumWidth     = 19;
  localparam int unsigned UdpBaseWidth   = 19;
  localparam int unsigned UdpProdWidth   = 26;
  localparam int unsigned MaxPacketBytes = 2048;

  // Fixed header contents
  localparam logic [15:0] VerIhlTos   = 16'h4500;
  localparam logic [7:0]  ProtoUdp    = 8'd17;
  localparam logic [15:0] IpHdrBytes  = 16'd20;
  localparam logic [15:0] UdpHdrBytes = 16'd8;
  localparam logic [15:0] NoChecksum  = 16'h0000;
  localparam logic [15:0] AllOnes     = 16'hFFFF;

  // Configuration port
  localparam int unsigned CfgIndexWidth = 2;
  localparam int unsigned CfgDataWidth  = 8;
  localparam logic [CfgIndexWidth-1:0] CfgTimeToLive = 2'd0;
  localparam logic [CfgIndexWidth-1:0] CfgFillByte   = 2'd1;
  localparam logic [7:0] TtlReset  = 8'h7F;
  localparam logic [7:0] FillReset = 8'h54;

  // Request beat
  typedef struct packed {
    logic [31:0]          dest_address;
    logic [15:0]          dest_port;
    logic [31:0]          source_address;
    logic [15:0]          source_port;
    logic [LenWidth-1:0]  payload_length;
  } req_t;

  // Header word beat
  typedef struct packed {
    logic [15:0]          header_word;
    logic [PosWidth-1:0]  word_position;
    logic                 last_word;
  } hdr_beat_t;

  // Header fields and raw checksum sums handed to the emitter
  typedef struct packed {
    logic [15:0]             total_len;
    logic [15:0]             packet_id;
    logic [7:0]              ttl;
    logic [31:0]             source_address;
    logic [31:0]             dest_address;
    logic [15:0]             source_port;
    logic [15:0]             dest_port;
    logic [15:0]             udp_len;
    logic [IpSumWidth-1:0]   ip_sum;
    logic [UdpBaseWidth-1:0] udp_base;
    logic [UdpProdWidth-1:0] udp_prod;
  } hdr_calc_t;

endpackage

>>> rtl/iuhg_emit.sv
// Checksum fold and fourteen-word header serialiser.
`timescale 1ns / 1ps

module iuhg_emit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  iuhg_pkg::hdr_calc_t calc_i,
  output logic                can_load_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output iuhg_pkg::hdr_beat_t out_data_o
);

  localparam logic [iuhg_pkg::PosWidth-1:0] LastPos =
    iuhg_pkg::PosWidth'(iuhg_pkg::NumWords - 1);
  localparam int unsigned UdpTotWidth = iuhg_pkg::UdpProdWidth + 1;

  logic [15:0]                   words_q [iuhg_pkg::NumWords];
  logic [15:0]                   words_d [iuhg_pkg::NumWords];
  logic [iuhg_pkg::PosWidth-1:0] pos_q, pos_d;
  logic                          busy_q, busy_d;
  logic                          beat_done;
  logic                          last_done;

  logic [16:0]            ip_fold1;
  logic [15:0]            ip_fold2;
  logic [UdpTotWidth-1:0] udp_total;
  logic [16:0]            udp_fold1;
  logic [15:0]            udp_fold2;
  logic [15:0]            udp_ck;

  assign beat_done  = busy_q && !out_stall_i;
  assign last_done  = beat_done && (pos_q == LastPos);
  assign can_load_o = !busy_q || last_done;

  // Fold the IPv4 sum down to sixteen bits
  always_comb begin
    ip_fold1 = 17'(calc_i.ip_sum[15:0]) + 17'(calc_i.ip_sum[iuhg_pkg::IpSumWidth-1:16]);
    ip_fold2 = ip_fold1[15:0] + 16'(ip_fold1[16]);
  end

  // Add the payload product, fold, and send zero as all ones
  always_comb begin
    udp_total = UdpTotWidth'(calc_i.udp_prod) + UdpTotWidth'(calc_i.udp_base);
    udp_fold1 = 17'(udp_total[15:0]) + 17'(udp_total[UdpTotWidth-1:16]);
    udp_fold2 = udp_fold1[15:0] + 16'(udp_fold1[16]);
    udp_ck    = ~udp_fold2;
    if (udp_ck == iuhg_pkg::NoChecksum) begin
      udp_ck = iuhg_pkg::AllOnes;
    end
  end

  // Load a fresh header or shift the current one along
  always_comb begin
    words_d = words_q;
    pos_d   = pos_q;
    busy_d  = busy_q;
    if (load_i) begin
      words_d[0]  = iuhg_pkg::VerIhlTos;
      words_d[1]  = calc_i.total_len;
      words_d[2]  = calc_i.packet_id;
      words_d[3]  = 16'h0000;
      words_d[4]  = {calc_i.ttl, iuhg_pkg::ProtoUdp};
      words_d[5]  = ~ip_fold2;
      words_d[6]  = calc_i.source_address[31:16];
      words_d[7]  = calc_i.source_address[15:0];
      words_d[8]  = calc_i.dest_address[31:16];
      words_d[9]  = calc_i.dest_address[15:0];
      words_d[10] = calc_i.source_port;
      words_d[11] = calc_i.dest_port;
      words_d[12] = calc_i.udp_len;
      words_d[13] = udp_ck;
      pos_d       = '0;
      busy_d      = 1'b1;
    end else if (beat_done) begin
      for (int i = 0; i < iuhg_pkg::NumWords - 1; i++) begin
        words_d[i] = words_q[i+1];
      end
      if (last_done) begin
        busy_d = 1'b0;
      end else begin
        pos_d = pos_q + iuhg_pkg::PosWidth'(1);
      end
    end
  end

  // Hold the word buffer
  always_ff @(posedge clk_i) begin
    words_q <= words_d;
  end

  // Hold position and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      busy_q <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      busy_q <= busy_d;
    end
  end

  assign out_valid_o              = busy_q;
  assign out_data_o.header_word   = words_q[0];
  assign out_data_o.word_position = pos_q;
  assign out_data_o.last_word     = (pos_q == LastPos);

endmodule

>>> rtl/ipv4_udp_header_generator_top.sv
// Top level of the IPv4/UDP header generator.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  request  | in_valid_i / in_stall_o    | in_data_i   (iuhg_pkg::req_t)
//  header   | out_valid_o / out_stall_i  | out_data_o  (iuhg_pkg::hdr_beat_t)
//  config   | cfg_we_i                   | cfg_index_i, cfg_wdata_i
//
// Each request yields fourteen header beats; the 16-bit header port limits
// throughput. The first beat follows the request beat through the input
// register, the sum stage and the word buffer. Reset is asynchronous and
// active low; it clears the identification counter and loads TTL 127 and
// fill byte 0x54. A stalled header beat holds; up to two requests queue
// behind the word buffer before in_stall_o rises.
`timescale 1ns / 1ps

module ipv4_udp_header_generator_top #(
  parameter int unsigned MAX_PACKET_BYTES = iuhg_pkg::MaxPacketBytes
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  iuhg_pkg::req_t                       in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output iuhg_pkg::hdr_beat_t                  out_data_o,
  input  logic                                 cfg_we_i,
  input  logic [iuhg_pkg::CfgIndexWidth-1:0]   cfg_index_i,
  input  logic [iuhg_pkg::CfgDataWidth-1:0]    cfg_wdata_i
);

  localparam logic [15:0] PayloadCap = 16'(MAX_PACKET_BYTES - 31);

  logic [7:0]                    ttl_q;
  logic [7:0]                    fill_q;
  logic [15:0]                   pkt_id_q;
  logic                          in_v_q;
  iuhg_pkg::req_t                req_q;
  iuhg_pkg::req_t                req_sat;
  logic [15:0]                   req_id_q;
  logic                          mid_v_q;
  iuhg_pkg::hdr_calc_t           calc_q, calc_d;
  logic                          can_load;
  logic                          mid_free;
  logic                          in_accept;
  logic                          in_adv;
  logic [iuhg_pkg::LenWidth-1:0] len_sat;

  // Pipeline flow
  assign mid_free   = !mid_v_q || can_load;
  assign in_adv     = in_v_q && mid_free;
  assign in_stall_o = in_v_q && !mid_free;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q  <= iuhg_pkg::TtlReset;
      fill_q <= iuhg_pkg::FillReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        iuhg_pkg::CfgTimeToLive: ttl_q  <= cfg_wdata_i;
        iuhg_pkg::CfgFillByte:   fill_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Saturate the payload length
  assign len_sat = (16'(in_data_i.payload_length) > PayloadCap)
                   ? PayloadCap[iuhg_pkg::LenWidth-1:0]
                   : in_data_i.payload_length;

  always_comb begin
    req_sat                = in_data_i;
    req_sat.payload_length = len_sat;
  end

  // Input register and identification counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q   <= 1'b0;
      pkt_id_q <= '0;
    end else begin
      if (in_accept) begin
        in_v_q   <= 1'b1;
        pkt_id_q <= pkt_id_q + 16'd1;
      end else if (in_adv) begin
        in_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      req_q    <= req_sat;
      req_id_q <= pkt_id_q;
    end
  end

  // Build header fields, raw sums and the payload product
  always_comb begin
    calc_d.total_len      = iuhg_pkg::IpHdrBytes + iuhg_pkg::UdpHdrBytes
                            + 16'(req_q.payload_length);
    calc_d.udp_len        = iuhg_pkg::UdpHdrBytes + 16'(req_q.payload_length);
    calc_d.packet_id      = req_id_q;
    calc_d.ttl            = ttl_q;
    calc_d.source_address = req_q.source_address;
    calc_d.dest_address   = req_q.dest_address;
    calc_d.source_port    = req_q.source_port;
    calc_d.dest_port      = req_q.dest_port;
    calc_d.ip_sum = iuhg_pkg::IpSumWidth'(iuhg_pkg::VerIhlTos)
                  + iuhg_pkg::IpSumWidth'(calc_d.total_len)
                  + iuhg_pkg::IpSumWidth'(req_id_q)
                  + iuhg_pkg::IpSumWidth'({ttl_q, iuhg_pkg::ProtoUdp})
                  + iuhg_pkg::IpSumWidth'(req_q.source_address[31:16])
                  + iuhg_pkg::IpSumWidth'(req_q.source_address[15:0])
                  + iuhg_pkg::IpSumWidth'(req_q.dest_address[31:16])
                  + iuhg_pkg::IpSumWidth'(req_q.dest_address[15:0]);
    calc_d.udp_base = iuhg_pkg::UdpBaseWidth'(req_q.source_address[31:16])
                    + iuhg_pkg::UdpBaseWidth'(req_q.source_address[15:0])
                    + iuhg_pkg::UdpBaseWidth'(req_q.dest_address[31:16])
                    + iuhg_pkg::UdpBaseWidth'(req_q.dest_address[15:0])
                    + iuhg_pkg::UdpBaseWidth'(iuhg_pkg::ProtoUdp)
                    + iuhg_pkg::UdpBaseWidth'({calc_d.udp_len, 1'b0})
                    + iuhg_pkg::UdpBaseWidth'(req_q.source_port)
                    + iuhg_pkg::UdpBaseWidth'(req_q.dest_port)
                    + (req_q.payload_length[0]
                       ? iuhg_pkg::UdpBaseWidth'({fill_q, 8'h00})
                       : '0);
    // Pairs of fill bytes: word value is fill * 257
    calc_d.udp_prod =
      iuhg_pkg::UdpProdWidth'(req_q.payload_length[iuhg_pkg::LenWidth-1:1])
      * iuhg_pkg::UdpProdWidth'({fill_q, fill_q});
  end

  // Sum stage register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_v_q <= 1'b0;
    end else if (mid_free) begin
      mid_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_adv) begin
      calc_q <= calc_d;
    end
  end

  iuhg_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (mid_v_q && can_load),
    .calc_i      (calc_q),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A taken beat that is not the last is followed by the next position
  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last_word
    |=> out_valid_o && (out_data_o.word_position == $past(out_data_o.word_position) + 4'd1))
    else $error("header word position did not advance");

  // An empty input register never stalls the request side
  a_no_idle_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_v_q |-> !in_stall_o)
    else $error("request stalled with empty input register");

  // Each accepted request takes the next identification
  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> (req_id_q == $past(pkt_id_q)) && (pkt_id_q == $past(pkt_id_q) + 16'd1))
    else $error("identification counter out of step");

endmodule

>>> tb/header_word_checker.sv
// Predicts the IPv4/UDP header words of each request and checks the header beats.
`timescale 1ns / 1ps

module header_word_checker
  import iuhg_pkg::*;
#(
  parameter int unsigned MAX_PACKET_BYTES = MaxPacketBytes
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  req_t                     in_data_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  hdr_beat_t                out_data_i,
  input  logic                     cfg_we_i,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgDataWidth-1:0]  cfg_wdata_i,
  output int unsigned              words_pending_o,
  output int unsigned              mismatches_o
);

  localparam int unsigned LenCap = MAX_PACKET_BYTES - 31;

  logic [7:0]  ttl_q;
  logic [7:0]  fill_q;
  logic [15:0] packet_id_q;
  hdr_beat_t   header_words_due[$];
  hdr_beat_t   due_beat;
  int unsigned mismatch_cnt;

  // Fold carries back in until the sum fits 16 bits
  function automatic logic [15:0] fold_ones(input logic [63:0] sum);
    logic [63:0] acc;
    acc = sum;
    while (acc[63:16] != '0) begin
      acc = {48'b0, acc[15:0]} + {16'b0, acc[63:16]};
    end
    return acc[15:0];
  endfunction

  // Work out the fourteen header words of one request and queue them
  function automatic void queue_header_words(input req_t req);
    logic [15:0]         w [NumWords];
    logic [LenWidth-1:0] len;
    logic [63:0]         ip_sum;
    logic [63:0]         udp_sum;
    logic [15:0]         udp_ck;
    hdr_beat_t           beat;
    int                  i;

    // Saturate long payloads
    len = (req.payload_length > LenCap) ? LenWidth'(LenCap) : req.payload_length;

    w[0]  = VerIhlTos;
    w[1]  = IpHdrBytes + UdpHdrBytes + 16'(len);
    w[2]  = packet_id_q;
    w[3]  = 16'h0000;
    w[4]  = {ttl_q, ProtoUdp};
    w[5]  = 16'h0000;
    w[6]  = req.source_address[31:16];
    w[7]  = req.source_address[15:0];
    w[8]  = req.dest_address[31:16];
    w[9]  = req.dest_address[15:0];
    w[10] = req.source_port;
    w[11] = req.dest_port;
    w[12] = UdpHdrBytes + 16'(len);
    w[13] = 16'h0000;

    // IPv4 header checksum over the first ten words
    ip_sum = '0;
    for (i = 0; i < 10; i++) begin
      ip_sum += 64'(w[i]);
    end
    w[5] = ~fold_ones(ip_sum);

    // UDP checksum: pseudo-header, UDP header, then a payload of fill bytes
    udp_sum = 64'(w[6]) + 64'(w[7]) + 64'(w[8]) + 64'(w[9]) + 64'(ProtoUdp) + 64'(w[12])
            + 64'(w[10]) + 64'(w[11]) + 64'(w[12])
            + 64'(len >> 1) * (64'(fill_q) * 64'd257);
    if (len[0]) begin
      udp_sum += {48'b0, fill_q, 8'h00};
    end
    udp_ck = ~fold_ones(udp_sum);
    // Zero on the wire means no checksum, so send all ones instead
    w[13] = (udp_ck == NoChecksum) ? AllOnes : udp_ck;

    packet_id_q = packet_id_q + 16'd1;

    for (i = 0; i < NumWords; i++) begin
      beat.header_word   = w[i];
      beat.word_position = PosWidth'(i);
      beat.last_word     = (i == NumWords - 1);
      header_words_due.push_back(beat);
    end
  endfunction

  // Track registers, predict on each request beat, compare each header beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ttl_q        = TtlReset;
      fill_q       = FillReset;
      packet_id_q  = 16'd0;
      mismatch_cnt = 0;
      header_words_due.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgTimeToLive: ttl_q = cfg_wdata_i;
          CfgFillByte:   fill_q = cfg_wdata_i;
          default: ;  // spare indexes hold nothing
        endcase
      end

      // Compare before queueing so a premature beat cannot match new words
      if (out_valid_i && !out_stall_i) begin
        if (header_words_due.size() == 0) begin
          $display("%0t: unexpected header beat: expected none, actual word %h pos %0d last %b",
                   $time, out_data_i.header_word, out_data_i.word_position,
                   out_data_i.last_word);
          mismatch_cnt++;
        end else begin
          due_beat = header_words_due.pop_front();
          if (out_data_i.header_word !== due_beat.header_word) begin
            $display("%0t: header_word at pos %0d: expected %h, actual %h", $time,
                     due_beat.word_position, due_beat.header_word, out_data_i.header_word);
            mismatch_cnt++;
          end
          if (out_data_i.word_position !== due_beat.word_position) begin
            $display("%0t: word_position: expected %0d, actual %0d", $time,
                     due_beat.word_position, out_data_i.word_position);
            mismatch_cnt++;
          end
          if (out_data_i.last_word !== due_beat.last_word) begin
            $display("%0t: last_word at pos %0d: expected %b, actual %b", $time,
                     due_beat.word_position, due_beat.last_word, out_data_i.last_word);
            mismatch_cnt++;
          end
        end
      end

      if (in_valid_i && !in_stall_i) begin
        queue_header_words(in_data_i);
      end
    end
    words_pending_o <= header_words_due.size();
    mismatches_o    <= mismatch_cnt;
  end

endmodule

>>> tb/tb.sv
// Testbench top of the IPv4/UDP header generator: stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb;
  import iuhg_pkg::*;

  // Indexes past the last register; writes there must do nothing
  localparam logic [CfgIndexWidth-1:0] CfgSpareLo = 2'd2;
  localparam logic [CfgIndexWidth-1:0] CfgSpareHi = 2'd3;
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned PhaseItems    = 90;

  logic                     clk_i     = 1'b0;
  logic                     rst_ni    = 1'b0;
  logic                     in_valid  = 1'b0;
  logic                     in_stall;
  req_t                     in_data   = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  hdr_beat_t                out_data;
  logic                     cfg_we    = 1'b0;
  logic [CfgIndexWidth-1:0] cfg_index = CfgTimeToLive;
  logic [CfgDataWidth-1:0]  cfg_wdata = '0;

  int unsigned words_pending;
  int unsigned mismatches;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct       = 0;
  int unsigned quiet_cycles    = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  ipv4_udp_header_generator_top u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  header_word_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .in_data_i       (in_data),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .out_data_i      (out_data),
    .cfg_we_i        (cfg_we),
    .cfg_index_i     (cfg_index),
    .cfg_wdata_i     (cfg_wdata),
    .words_pending_o (words_pending),
    .mismatches_o    (mismatches)
  );

  // Stall the header channel at random
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Abort when no beat moves on either channel for too long
  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one request beat, with random idle cycles first, and hold it until taken
  task automatic send_request(input req_t req);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk_i);
    while (in_stall) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_register(input logic [CfgIndexWidth-1:0] idx,
                                input logic [CfgDataWidth-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold off until every predicted header word has arrived, then let the pipe settle
  task automatic drain_headers();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (words_pending != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic req_t random_request();
    req_t req;
    req.dest_address   = $urandom();
    req.dest_port      = 16'($urandom_range(65535));
    req.source_address = $urandom();
    req.source_port    = 16'($urandom_range(65535));
    // Lean on the saturation edge and on tiny payloads now and then
    case ($urandom_range(7))
      0:       req.payload_length = 11'($urandom_range(2047, 2010));
      1:       req.payload_length = 11'($urandom_range(3));
      default: req.payload_length = 11'($urandom_range(2047));
    endcase
    return req;
  endfunction

  task automatic run_random_phase(input int unsigned items, input int unsigned idle,
                                  input int unsigned stall);
    sender_idle_pct = idle;
    stall_pct       = stall;
    repeat (items) send_request(random_request());
    drain_headers();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed beats at the reset settings: {dst, dport, src, sport, length}
    send_request({32'h0000_0000, 16'h0000, 32'h0000_0000, 16'h0000, 11'd0});
    send_request({32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 11'h7FF});
    send_request({32'hAAAA_AAAA, 16'h5555, 32'h5555_5555, 16'hAAAA, 11'h555});
    send_request({32'h5555_5555, 16'hAAAA, 32'hAAAA_AAAA, 16'h5555, 11'h2AA});
    send_request({$urandom(), 16'h0035, $urandom(), 16'hC000, 11'd2017});
    send_request({$urandom(), 16'h0044, $urandom(), 16'h0043, 11'd2018});
    send_request({$urandom(), 16'h1F90, $urandom(), 16'h8000, 11'd1});
    send_request({$urandom(), 16'h0001, $urandom(), 16'hFFFE, 11'd2});
    send_request({$urandom(), 16'h7FFF, $urandom(), 16'h0400, 11'd1024});
    // Computed UDP checksum of zero goes out as all ones, even and odd payloads
    send_request({32'h0000_0000, 16'h0000, 32'h0000_0000, 16'hFFDE, 11'd0});
    send_request({32'h0000_0000, 16'h0000, 32'h0000_0000, 16'hABDC, 11'd1});
    send_request({32'h0A00_0001, 16'h0000, 32'hFFFF_0000, 16'h0000, 11'd2016});
    send_request(random_request());
    send_request(random_request());
    drain_headers();

    // Lowest register values, no idling
    write_register(CfgTimeToLive, 8'd0);
    write_register(CfgFillByte, 8'd0);
    run_random_phase(PhaseItems, 0, 0);

    // Highest register values, sender idles half the time
    write_register(CfgTimeToLive, 8'd255);
    write_register(CfgFillByte, 8'd255);
    run_random_phase(PhaseItems, 50, 0);

    // Spare indexes must leave both registers alone
    write_register(CfgSpareLo, 8'($urandom_range(255)));
    write_register(CfgSpareHi, 8'($urandom_range(255)));
    run_random_phase(PhaseItems, 0, 50);

    write_register(CfgTimeToLive, 8'($urandom_range(255)));
    write_register(CfgFillByte, 8'($urandom_range(255)));
    run_random_phase(PhaseItems, 25, 25);

    write_register(CfgFillByte, 8'($urandom_range(255)));
    write_register(CfgTimeToLive, 8'($urandom_range(255)));
    run_random_phase(PhaseItems / 2, 0, 0);
    run_random_phase(PhaseItems / 2, 25, 25);

    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/iuhg_pkg.sv
rtl/iuhg_emit.sv
rtl/ipv4_udp_header_generator_top.sv
tb/header_word_checker.sv
tb/tb.sv
